// File: rtl/stt_pkg.sv
// Shared types and codes for the software timer table.
// Used by the controller, datapath and top level; no dependencies.
`default_nettype none
package stt_pkg;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;
   localparam logic [1:0] OP_TICK   = 2'd3;

   localparam logic [2:0] KIND_ADDED  = 3'd0;
   localparam logic [2:0] KIND_REMOVE = 3'd1;
   localparam logic [2:0] KIND_QUERY  = 3'd2;
   localparam logic [2:0] KIND_FIRED  = 3'd3;
   localparam logic [2:0] KIND_DONE   = 3'd4;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] now_ms;
      logic [31:0] delay_ms;
      logic        repeat_req;
      logic [31:0] timer_id;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] result_id;
      logic        ok;
      logic        last;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request, clear scan state
      logic scan;       // examine slot at scan index
      logic scan_reset; // restart scan index at zero
      logic pick_clear; // clear pick before a fire search pass
      logic fire;       // fire the picked slot
      logic add_commit; // apply an add
      logic ed_commit;  // write recomputed earliest deadline
      logic mark_due;   // first pass of a tick sets due bits
      logic rm_commit;  // apply a remove
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       scan_last;
      logic       tick_active;
      logic       pick_found;
      logic [1:0] operation;
   } sts_type;

endpackage
`default_nettype wire

// File: rtl/stt_datapath.sv
// Slot storage, scan index, id search, minimum search and result forming.
// Depends on stt_pkg.
`default_nettype none
module stt_datapath #(
   parameter int SLOTS = 16
) (
   input  wire                 clock,
   input  wire                 reset,
   input  stt_pkg::req_type    req_in,
   input  stt_pkg::cmd_type    cmd,
   output stt_pkg::sts_type    sts,
   output stt_pkg::rsp_type    rsp_out
);
   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [SLOTS-1:0] due_ff, due_in;
   logic [31:0]      id_mem [SLOTS];
   logic [31:0]      dl_mem [SLOTS];
   logic [31:0]      per_mem [SLOTS];
   logic [SLOTS-1:0] rep_ff;

   stt_pkg::req_type req_ff;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [31:0]      next_id_ff, next_id_in;
   logic [31:0]      ed_ff, ed_in;
   logic [31:0]      emin_ff, emin_in;
   logic             free_found_ff, free_found_in;
   logic [IW-1:0]    free_idx_ff, free_idx_in;
   logic             hit_ff, hit_in;
   logic [IW-1:0]    hit_idx_ff, hit_idx_in;
   logic             newid_hit_ff, newid_hit_in;
   logic             pick_ff, pick_in;
   logic [IW-1:0]    pick_idx_ff, pick_idx_in;
   logic [31:0]      pick_id_ff, pick_id_in;
   logic             tick_ff, tick_in;
   stt_pkg::rsp_type rsp_ff, rsp_in;

   logic [31:0] cur_id, cur_dl, target;
   logic        cur_v, cur_due;

   assign cur_v  = valid_ff[idx_ff];
   assign cur_id = id_mem[idx_ff];
   assign cur_dl = dl_mem[idx_ff];
   assign cur_due = due_ff[idx_ff];
   assign target = req_ff.now_ms + req_ff.delay_ms;

   always_comb begin
      valid_in = valid_ff;  due_in = due_ff;  idx_in = idx_ff;
      next_id_in = next_id_ff;  ed_in = ed_ff;  emin_in = emin_ff;
      free_found_in = free_found_ff;  free_idx_in = free_idx_ff;
      hit_in = hit_ff;  hit_idx_in = hit_idx_ff;  newid_hit_in = newid_hit_ff;
      pick_in = pick_ff;  pick_idx_in = pick_idx_ff;  pick_id_in = pick_id_ff;
      tick_in = tick_ff;  rsp_in = rsp_ff;
      if (cmd.load) begin
         idx_in = '0;  emin_in = '0;  free_found_in = 1'b0;  hit_in = 1'b0;
         newid_hit_in = 1'b0;  pick_in = 1'b0;
         tick_in = (ed_ff != 32'd0) && (req_in.now_ms >= ed_ff);
      end
      if (cmd.scan_reset) idx_in = '0;
      if (cmd.pick_clear) pick_in = 1'b0;
      if (cmd.scan) begin
         if (!cur_v && !free_found_ff) begin
            free_found_in = 1'b1;  free_idx_in = idx_ff;
         end
         if (cur_v && cur_id == req_ff.timer_id && !hit_ff) begin
            hit_in = 1'b1;  hit_idx_in = idx_ff;
         end
         if (cur_v && cur_id == next_id_ff) newid_hit_in = 1'b1;
         if (cmd.mark_due) due_in[idx_ff] = cur_v && (req_ff.now_ms >= cur_dl);
         else if (cur_due && (!pick_ff || cur_id < pick_id_ff)) begin
            pick_in = 1'b1;  pick_idx_in = idx_ff;  pick_id_in = cur_id;
         end
         if (cur_v && cur_dl > req_ff.now_ms && (cur_dl < emin_ff || emin_ff == 32'd0)
             && !(req_ff.operation == stt_pkg::OP_REMOVE && cur_id == req_ff.timer_id)
             && !cmd.mark_due)
            emin_in = cur_dl;
         idx_in = (idx_ff == IW'(SLOTS - 1)) ? '0 : idx_ff + IW'(1);
      end
      if (cmd.fire) begin
         due_in[pick_idx_ff] = 1'b0;
         if (!rep_ff[pick_idx_ff]) valid_in[pick_idx_ff] = 1'b0;
         rsp_in = '{kind: stt_pkg::KIND_FIRED, result_id: pick_id_ff, ok: 1'b1, last: 1'b0};
      end
      if (cmd.rm_commit) begin
         if (hit_ff) valid_in[hit_idx_ff] = 1'b0;
         ed_in = emin_ff;
         rsp_in = '{kind: stt_pkg::KIND_REMOVE, result_id: req_ff.timer_id,
                    ok: hit_ff, last: 1'b1};
      end
      if (cmd.ed_commit) begin
         ed_in = tick_ff ? emin_ff : ed_ff;
         rsp_in = '{kind: stt_pkg::KIND_DONE, result_id: 32'd0, ok: 1'b0, last: 1'b1};
      end
      if (cmd.add_commit) begin
         if (!free_found_ff)
            rsp_in = '{kind: stt_pkg::KIND_ADDED, result_id: 32'd0, ok: 1'b0, last: 1'b1};
         else begin
            next_id_in = next_id_ff + 32'd1;
            if (target < ed_ff || ed_ff == 32'd0) ed_in = target;
            if (!newid_hit_ff) valid_in[free_idx_ff] = 1'b1;
            rsp_in = '{kind: stt_pkg::KIND_ADDED, result_id: next_id_ff,
                       ok: !newid_hit_ff, last: 1'b1};
         end
      end
      if (req_ff.operation == stt_pkg::OP_QUERY && cmd.ed_commit == 1'b0 && cmd.scan == 1'b0
          && cmd.fire == 1'b0 && cmd.rm_commit == 1'b0 && cmd.add_commit == 1'b0
          && cmd.mark_due == 1'b0 && cmd.load == 1'b0 && cmd.pick_clear == 1'b1)
         rsp_in = '{kind: stt_pkg::KIND_QUERY, result_id: req_ff.timer_id,
                    ok: hit_ff, last: 1'b1};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;  due_ff <= '0;  next_id_ff <= '0;  ed_ff <= '0;
         idx_ff <= '0;  tick_ff <= 1'b0;  pick_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;  due_ff <= due_in;  next_id_ff <= next_id_in;
         ed_ff <= ed_in;  idx_ff <= idx_in;  tick_ff <= tick_in;  pick_ff <= pick_in;
      end
      emin_ff <= emin_in;  free_found_ff <= free_found_in;  free_idx_ff <= free_idx_in;
      hit_ff <= hit_in;  hit_idx_ff <= hit_idx_in;  newid_hit_ff <= newid_hit_in;
      pick_idx_ff <= pick_idx_in;  pick_id_ff <= pick_id_in;  rsp_ff <= rsp_in;
      if (cmd.load) req_ff <= req_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.add_commit && free_found_ff && !newid_hit_ff) begin
         id_mem[free_idx_ff]  <= next_id_ff;
         dl_mem[free_idx_ff]  <= target;
         per_mem[free_idx_ff] <= req_ff.delay_ms;
         rep_ff[free_idx_ff]  <= req_ff.repeat_req;
      end else if (cmd.fire && rep_ff[pick_idx_ff])
         dl_mem[pick_idx_ff] <= req_ff.now_ms + per_mem[pick_idx_ff];
   end

   assign sts.scan_last   = (idx_ff == IW'(SLOTS - 1));
   assign sts.tick_active = tick_ff;
   assign sts.pick_found  = pick_ff;
   assign sts.operation   = req_ff.operation;
   assign rsp_out = rsp_ff;

   a_fire_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.fire |-> pick_ff && valid_ff[pick_idx_ff])
      else $error("fire on invalid slot");
   a_fire_clears_due: assert property (@(posedge clock) disable iff (reset)
      cmd.fire |=> !due_ff[$past(pick_idx_ff)])
      else $error("due bit kept after fire");
   a_next_id_step: assert property (@(posedge clock) disable iff (reset)
      !cmd.add_commit |=> next_id_ff == $past(next_id_ff))
      else $error("id counter moved outside add");
endmodule
`default_nettype wire

// File: rtl/stt_ctrl.sv
// Sequencer for the timer table: scan passes, fire loop, result handshake.
// Depends on stt_pkg.
`default_nettype none
module stt_ctrl (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   input  stt_pkg::sts_type  sts,
   output stt_pkg::cmd_type  cmd
);
   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_SCAN  = 9'b000000010,
      S_DONE  = 9'b000000100,
      S_MARK  = 9'b000001000,
      S_PICK  = 9'b000010000,
      S_FIRE  = 9'b000100000,
      S_MIN   = 9'b001000000,
      S_FINAL = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      out_final_ff, out_final_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      take;

   assign take = rsp_valid_ff && !rsp_stall;

   always_comb begin
      state_in = state_ff;
      out_final_in = out_final_ff;
      rsp_valid_in = rsp_valid_ff && !take;
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.operation == stt_pkg::OP_TICK) begin
               if (sts.tick_active) state_in = S_MARK;
               else begin
                  cmd.ed_commit = 1'b0;
                  state_in = S_DONE;
               end
            end else begin
               cmd.scan = 1'b1;
               if (sts.scan_last) state_in = S_DONE;
            end
         end
         S_DONE: begin
            case (sts.operation)
               stt_pkg::OP_ADD:    cmd.add_commit = 1'b1;
               stt_pkg::OP_REMOVE: cmd.rm_commit = 1'b1;
               stt_pkg::OP_QUERY:  cmd.pick_clear = 1'b1;
               default:            cmd.ed_commit = 1'b0;
            endcase
            if (sts.operation == stt_pkg::OP_TICK) state_in = S_FINAL;
            else begin
               rsp_valid_in = 1'b1;
               out_final_in = 1'b1;
               state_in = S_OUT;
            end
         end
         S_MARK: begin
            cmd.scan = 1'b1;
            cmd.mark_due = 1'b1;
            if (sts.scan_last) begin
               cmd.pick_clear = 1'b1;
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) state_in = S_FIRE;
         end
         S_FIRE: begin
            if (sts.pick_found) begin
               cmd.fire = 1'b1;
               cmd.pick_clear = 1'b1;
               rsp_valid_in = 1'b1;
               out_final_in = 1'b0;
               state_in = S_OUT;
            end else state_in = S_MIN;
         end
         S_MIN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) state_in = S_FINAL;
         end
         S_FINAL: begin
            cmd.ed_commit = 1'b1;
            rsp_valid_in = 1'b1;
            out_final_in = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (take) state_in = out_final_ff ? S_IDLE : S_PICK;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         out_final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         out_final_ff <= out_final_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT |-> rsp_valid_ff)
      else $error("output state without valid");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> req_stall)
      else $error("request accepted while result pending");
endmodule
`default_nettype wire

// File: rtl/software_timer_table_core.sv
// Software timer table: add, remove, query and tick over a table of SLOTS timers.
// Add, remove, query and non-idle tick requests walk the slots one per cycle through the
// single-slot scan port; an idle tick skips the scan. A tick fires due timers one at a time,
// lowest id first, each after its own search pass. A new request is taken only after the
// last result has been accepted. Results leave through a registered valid/stall channel.
`default_nettype none
module software_timer_table_core #(
   parameter int SLOTS = 16
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  stt_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output stt_pkg::rsp_type  rsp_data
);
   stt_pkg::cmd_type cmd;
   stt_pkg::sts_type sts;

   stt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .sts(sts), .cmd(cmd)
   );

   stt_datapath #(.SLOTS(SLOTS)) u_dp (
      .clock(clock), .reset(reset), .req_in(req_data), .cmd(cmd), .sts(sts),
      .rsp_out(rsp_data)
   );
endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for software_timer_table_core: add, remove, query and tick requests.
// Holds its own timer-table predictor; depends on stt_pkg and the core RTL.
`timescale 1ns / 1ps
module testbench;

   localparam int SLOTS = 16;
   localparam int WATCHDOG_LIMIT = 200000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   stt_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   stt_pkg::rsp_type rsp_data;

   software_timer_table_core #(.SLOTS(SLOTS)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // predictor state
   logic        tbl_valid[SLOTS];
   logic [31:0] tbl_id[SLOTS];
   logic [31:0] tbl_deadline[SLOTS];
   logic [31:0] tbl_period[SLOTS];
   logic        tbl_repeat[SLOTS];
   logic [31:0] id_counter;
   logic [31:0] soonest;

   stt_pkg::req_type pending_reqs[$];
   stt_pkg::rsp_type expected_rsps[$];
   int      error_count = 0;
   int      idle_cycles = 0;
   bit      stim_done = 1'b0;
   int      send_gap = 0;
   int      recv_gap = 0;
   int      hold_count = 0;   // sender waits for drain when this equals the pending queue size

   task automatic report(input string msg);
      $display("ERROR %0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic stt_pkg::rsp_type make_rsp(logic [2:0] k, logic [31:0] id, logic ok,
                                                 logic lst);
      stt_pkg::rsp_type r;
      r.kind = k; r.result_id = id; r.ok = ok; r.last = lst;
      return r;
   endfunction

   function automatic void refresh_soonest(logic [31:0] now);
      logic [31:0] e;
      e = 0;
      for (int i = 0; i < SLOTS; i++)
         if (tbl_valid[i] && tbl_deadline[i] > now && (tbl_deadline[i] < e || e == 0))
            e = tbl_deadline[i];
      soonest = e;
   endfunction

   function automatic int find_slot(logic [31:0] id);
      for (int i = 0; i < SLOTS; i++)
         if (tbl_valid[i] && tbl_id[i] == id) return i;
      return -1;
   endfunction

   function automatic void predict_timer_table(stt_pkg::req_type rq);
      int          free_slot, s, pick;
      logic [31:0] target;
      logic        due[SLOTS];
      free_slot = -1;
      case (rq.operation)
         stt_pkg::OP_ADD: begin
            for (int i = SLOTS - 1; i >= 0; i--)
               if (!tbl_valid[i]) free_slot = i;
            if (free_slot < 0) begin
               expected_rsps.push_back(make_rsp(stt_pkg::KIND_ADDED, 0, 1'b0, 1'b1));
            end else begin
               target = rq.now_ms + rq.delay_ms;
               s = find_slot(id_counter);
               if (s < 0) begin
                  tbl_valid[free_slot] = 1'b1;
                  tbl_id[free_slot] = id_counter;
                  tbl_deadline[free_slot] = target;
                  tbl_period[free_slot] = rq.delay_ms;
                  tbl_repeat[free_slot] = rq.repeat_req;
               end
               if (target < soonest || soonest == 0) soonest = target;
               expected_rsps.push_back(make_rsp(stt_pkg::KIND_ADDED, id_counter, s < 0,
                                                1'b1));
               id_counter++;
            end
         end
         stt_pkg::OP_REMOVE: begin
            s = find_slot(rq.timer_id);
            if (s >= 0) tbl_valid[s] = 1'b0;
            refresh_soonest(rq.now_ms);
            expected_rsps.push_back(make_rsp(stt_pkg::KIND_REMOVE, rq.timer_id, s >= 0,
                                             1'b1));
         end
         stt_pkg::OP_QUERY:
            expected_rsps.push_back(make_rsp(stt_pkg::KIND_QUERY, rq.timer_id,
                                             find_slot(rq.timer_id) >= 0, 1'b1));
         default: begin
            if (soonest != 0 && rq.now_ms >= soonest) begin
               for (int i = 0; i < SLOTS; i++)
                  due[i] = tbl_valid[i] && rq.now_ms >= tbl_deadline[i];
               forever begin
                  pick = -1;
                  for (int i = 0; i < SLOTS; i++)
                     if (due[i] && (pick < 0 || tbl_id[i] < tbl_id[pick])) pick = i;
                  if (pick < 0) break;
                  due[pick] = 1'b0;
                  expected_rsps.push_back(make_rsp(stt_pkg::KIND_FIRED, tbl_id[pick], 1'b1,
                                                   1'b0));
                  if (tbl_repeat[pick])
                     tbl_deadline[pick] = rq.now_ms + tbl_period[pick];
                  else
                     tbl_valid[pick] = 1'b0;
               end
               refresh_soonest(rq.now_ms);
            end
            expected_rsps.push_back(make_rsp(stt_pkg::KIND_DONE, 0, 1'b0, 1'b1));
         end
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] id_guess(int n);
      return $urandom_range(0, n / 2 + 30);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_timer_table(req_data);
         end
         if (req_valid && req_stall) begin
            // hold payload
         end else if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_reqs.size() > 0 &&
                      !(hold_count == pending_reqs.size() && expected_rsps.size() > 0)) begin
            req_valid <= 1'b1;
            req_data <= pending_reqs.pop_front();
            send_gap <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      stt_pkg::rsp_type exp_r;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               report($sformatf("unexpected response kind=%0d id=%0d",
                                rsp_data.kind, rsp_data.result_id));
            end else begin
               exp_r = expected_rsps.pop_front();
               if (rsp_data.kind !== exp_r.kind)
                  report($sformatf("kind %0d, expected %0d", rsp_data.kind, exp_r.kind));
               if (rsp_data.result_id !== exp_r.result_id)
                  report($sformatf("result_id %0d, expected %0d",
                                   rsp_data.result_id, exp_r.result_id));
               if (rsp_data.ok !== exp_r.ok)
                  report($sformatf("ok %0b, expected %0b", rsp_data.ok, exp_r.ok));
               if (rsp_data.last !== exp_r.last)
                  report($sformatf("last %0b, expected %0b", rsp_data.last, exp_r.last));
            end
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (recv_gap > 0) begin
            rsp_stall <= 1'b1;
            recv_gap <= recv_gap - 1;
         end else begin
            rsp_stall <= 1'b0;
            if (!stim_done || $urandom_range(0, 3) == 0) recv_gap <= pick_gap();
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic push_req(logic [1:0] op, logic [31:0] now, logic [31:0] dly,
                           logic rep, logic [31:0] tid);
      stt_pkg::req_type r;
      r.operation = op; r.now_ms = now; r.delay_ms = dly;
      r.repeat_req = rep; r.timer_id = tid;
      pending_reqs.push_back(r);
   endtask

   initial begin
      logic [31:0] clk_ms;
      int          r;
      for (int i = 0; i < SLOTS; i++) begin
         tbl_valid[i] = 1'b0; tbl_id[i] = 0; tbl_deadline[i] = 0;
         tbl_period[i] = 0; tbl_repeat[i] = 1'b0;
      end
      id_counter = 0;
      soonest = 0;

      // directed
      push_req(stt_pkg::OP_TICK, 32'd0, 32'd0, 1'b0, 32'd0);           // idle tick
      push_req(stt_pkg::OP_ADD, 32'd0, 32'd0, 1'b1, 32'hFFFFFFFF);     // deadline zero
      push_req(stt_pkg::OP_TICK, 32'd5, 32'd0, 1'b0, 32'd0);
      push_req(stt_pkg::OP_QUERY, 32'd0, 32'd0, 1'b0, 32'd0);
      push_req(stt_pkg::OP_REMOVE, 32'd1, 32'd0, 1'b0, 32'd0);
      push_req(stt_pkg::OP_REMOVE, 32'd1, 32'd0, 1'b0, 32'd99);        // absent id
      push_req(stt_pkg::OP_ADD, 32'd10, 32'd5, 1'b1, 32'd0);           // repeating
      push_req(stt_pkg::OP_ADD, 32'd10, 32'd0, 1'b1, 32'd0);           // zero period
      push_req(stt_pkg::OP_ADD, 32'd10, 32'hFFFFFFFF, 1'b0, 32'd0);    // wrap
      push_req(stt_pkg::OP_ADD, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 32'd0);
      push_req(stt_pkg::OP_TICK, 32'd15, 32'd0, 1'b0, 32'd0);
      push_req(stt_pkg::OP_TICK, 32'd20, 32'd0, 1'b0, 32'd0);
      push_req(stt_pkg::OP_QUERY, 32'd0, 32'd0, 1'b0, 32'hFFFFFFFF);
      for (int i = 0; i < SLOTS + 1; i++)                  // fill past full
         push_req(stt_pkg::OP_ADD, 32'd30, 32'd3 + i[31:0], i[0], 32'd0);
      push_req(stt_pkg::OP_TICK, 32'hFFFFFFFF, 32'd0, 1'b0, 32'd0);

      // random
      clk_ms = 32'd100;
      for (int n = 0; n < 330; n++) begin
         r = $urandom_range(0, 99);
         if (n == 150) hold_count = pending_reqs.size() + 1;
         if (r < 35) begin
            push_req(stt_pkg::OP_ADD, clk_ms,
                     ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 60),
                     1'($urandom_range(0, 1)), $urandom);
         end else if (r < 50) begin
            push_req(stt_pkg::OP_REMOVE, clk_ms, $urandom, 1'($urandom_range(0, 1)),
                     ($urandom_range(0, 9) == 0) ? $urandom : id_guess(n));
         end else if (r < 62) begin
            push_req(stt_pkg::OP_QUERY, ($urandom_range(0, 9) == 0) ? $urandom : clk_ms,
                     $urandom, 1'($urandom_range(0, 1)),
                     ($urandom_range(0, 9) == 0) ? $urandom : id_guess(n));
         end else begin
            clk_ms = clk_ms + $urandom_range(0, 30);
            push_req(stt_pkg::OP_TICK, clk_ms, $urandom, 1'($urandom_range(0, 1)), $urandom);
         end
         if ($urandom_range(0, 99) == 0) clk_ms = $urandom;
      end
      stim_done = 1'b1;
   end

   // reset, completion
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done && pending_reqs.size() == 0);
      @(posedge clock);
      while (req_valid || expected_rsps.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
